/* hdl/abrp_pkg.sv */
// Shared types and constants for the audio block ring playback design.
// No dependencies; imported by every module of the block except abrp_ram.
package abrp_pkg;

    localparam int ACT_W      = 2;
    localparam int FIDX_W     = 8;
    localparam int SMP_W      = 16;
    localparam int CNT_W      = 7;
    localparam int QCNT_W     = 5;
    localparam int UND_W      = 32;
    localparam int CFG_FPB_W  = 9;
    localparam int CFG_BLK_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int CFG_FPB_MAX = (1 << CFG_FPB_W) - 1;
    localparam int CFG_BLK_MAX = (1 << CFG_BLK_W) - 1;

    localparam logic [CNT_W-1:0]     PULL_LIMIT = 7'd64;
    localparam logic [CFG_FPB_W-1:0] FPB_RESET  = 9'd128;
    localparam logic [CFG_BLK_W-1:0] BLK_RESET  = 5'd16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_WRITE   = 2'd1,
        ACT_COMMIT  = 2'd2,
        ACT_PULL    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAMES_PER_BLOCK = 2'd0,
        CFG_BLOCKS_IN_USE    = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FRAMES
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic latch;
        logic exec_op;
        logic exec_frame;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_pull;
        logic pull_zero;
        logic frame_last;
        logic issue_ok;
    } dp_status_t;

endpackage

/* hdl/abrp_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module abrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* hdl/abrp_ctrl.sv */
// Sequencer for the ring: clearing pass, item intake, single ops and frame steps.
// Depends on abrp_pkg.
module abrp_ctrl import abrp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output logic       in_stall,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_pull && !status.pull_zero)
                begin
                    state_next = ST_FRAMES;
                end
                else if (status.issue_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRAMES:
            begin
                if (status.issue_ok && status.frame_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.latch = in_valid;
            end
            ST_DECODE:
            begin
                cmd.exec_op = status.issue_ok && !(status.is_pull && !status.pull_zero);
            end
            ST_FRAMES:
            begin
                cmd.exec_frame = status.issue_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/abrp_dpath.sv */
// Ring datapath: config registers, ring pointers, underrun counter,
// result pending stage and output register. Depends on abrp_pkg; drives abrp_ram.
module abrp_dpath import abrp_pkg::*; #(
    parameter int MAX_RING_BLOCKS  = 16,
    parameter int MAX_BLOCK_FRAMES = 256,
    localparam int DEPTH  = MAX_RING_BLOCKS * MAX_BLOCK_FRAMES,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               status,
    input  logic                     cfg_valid,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [ACT_W-1:0]         action,
    input  logic [FIDX_W-1:0]        frame_index,
    input  logic signed [SMP_W-1:0]  left_in,
    input  logic signed [SMP_W-1:0]  right_in,
    input  logic [CNT_W-1:0]         pull_count,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [SMP_W-1:0]  left_out,
    output logic signed [SMP_W-1:0]  right_out,
    output logic                     last,
    output logic                     ok,
    output logic [QCNT_W-1:0]        queued_blocks,
    output logic                     has_space,
    output logic [UND_W-1:0]         underrun_count,
    output logic                     ram_we,
    output logic                     ram_re,
    output logic [ADDR_W-1:0]        ram_addr,
    output logic [2*SMP_W-1:0]       ram_wdata,
    input  logic [2*SMP_W-1:0]       ram_rdata
);

    localparam int FMAX  = (MAX_BLOCK_FRAMES < CFG_FPB_MAX) ? MAX_BLOCK_FRAMES : CFG_FPB_MAX;
    localparam int BMAX  = (MAX_RING_BLOCKS < CFG_BLK_MAX) ? MAX_RING_BLOCKS : CFG_BLK_MAX;
    localparam int OFF_W = (FMAX > 1) ? $clog2(FMAX) : 1;
    localparam int FPB_W = $clog2(FMAX + 1);
    localparam int BLK_W = (BMAX > 1) ? $clog2(BMAX) : 1;
    localparam int NW    = (BLK_W + 1 > CFG_BLK_W) ? BLK_W + 1 : CFG_BLK_W;
    localparam int CW    = (FPB_W > CNT_W) ? FPB_W : CNT_W;
    localparam int IW    = (FPB_W > FIDX_W) ? FPB_W : FIDX_W;

    function automatic logic [BLK_W-1:0] next_blk(input logic [BLK_W-1:0] b,
                                                  input logic [CFG_BLK_W-1:0] n);
        logic [NW-1:0] s;
        s = NW'(b) + NW'(1);
        next_blk = (s >= NW'(n)) ? '0 : BLK_W'(s);
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [BLK_W-1:0] b,
                                                     input logic [IW-1:0] f);
        store_addr = ADDR_W'(b) * ADDR_W'(MAX_BLOCK_FRAMES) + ADDR_W'(f);
    endfunction

    // control state
    logic [CFG_FPB_W-1:0] fpb_cfg_reg;
    logic [CFG_BLK_W-1:0] blk_cfg_reg;
    logic [BLK_W-1:0]     wb_reg, wb_next;
    logic [BLK_W-1:0]     rb_reg, rb_next;
    logic [QCNT_W-1:0]    q_reg, q_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic                 claimed_reg, claimed_next;
    logic                 ever_reg, ever_next;
    logic [UND_W-1:0]     und_reg, und_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     sil_reg, sil_next;
    logic                 p_valid_reg, p_valid_next;
    logic                 o_valid_reg, o_valid_next;

    // item and result payload
    action_t              act_reg;
    logic [FIDX_W-1:0]    fidx_reg;
    logic [2*SMP_W-1:0]   smp_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 p_play_reg, p_last_reg, p_ok_reg, p_space_reg;
    logic [QCNT_W-1:0]    p_q_reg;
    logic [UND_W-1:0]     p_und_reg;
    logic signed [SMP_W-1:0] o_left_reg, o_right_reg;
    logic                 o_last_reg, o_ok_reg, o_space_reg;
    logic [QCNT_W-1:0]    o_q_reg;
    logic [UND_W-1:0]     o_und_reg;

    logic [FPB_W-1:0]     fpb_eff;
    logic [CFG_BLK_W-1:0] blk_eff;
    logic                 fr_pre, fr_play, fr_rel, frame_last;
    logic [QCNT_W-1:0]    q1;
    logic [OFF_W-1:0]     off1;
    logic [BLK_W-1:0]     rb1;
    logic [FPB_W-1:0]     off_inc;
    logic [CNT_W-1:0]     rem, sil_start;
    logic [UND_W-1:0]     und_inc;
    logic                 ok_next;
    logic                 exec;
    logic                 o_take, p_move;

    always_comb
    begin
        if (fpb_cfg_reg == '0)
        begin
            fpb_eff = FPB_W'(1);
        end
        else if (fpb_cfg_reg > CFG_FPB_W'(FMAX))
        begin
            fpb_eff = FPB_W'(FMAX);
        end
        else
        begin
            fpb_eff = FPB_W'(fpb_cfg_reg);
        end
        if (blk_cfg_reg == '0)
        begin
            blk_eff = CFG_BLK_W'(1);
        end
        else if (blk_cfg_reg > CFG_BLK_W'(BMAX))
        begin
            blk_eff = CFG_BLK_W'(BMAX);
        end
        else
        begin
            blk_eff = blk_cfg_reg;
        end
    end

    // one frame step: release a stale block, then play or go silent
    assign fr_pre     = (q_reg != '0) && (FPB_W'(off_reg) >= fpb_eff);
    assign q1         = fr_pre ? q_reg - QCNT_W'(1) : q_reg;
    assign off1       = fr_pre ? '0 : off_reg;
    assign rb1        = fr_pre ? next_blk(rb_reg, blk_eff) : rb_reg;
    assign fr_play    = (sil_reg == '0) && (q1 != '0);
    assign off_inc    = FPB_W'(off1) + FPB_W'(1);
    assign fr_rel     = off_inc >= fpb_eff;
    assign rem        = cnt_reg - k_reg;
    assign sil_start  = (CW'(rem) < CW'(fpb_eff)) ? rem : CNT_W'(fpb_eff);
    assign und_inc    = (ever_reg && (und_reg != '1)) ? und_reg + UND_W'(1) : und_reg;
    assign frame_last = (k_reg + CNT_W'(1)) == cnt_reg;

    assign exec   = cmd.exec_op || cmd.exec_frame;
    assign o_take = !o_valid_reg || !out_stall;
    assign p_move = p_valid_reg && o_take;

    always_comb
    begin
        wb_next      = wb_reg;
        rb_next      = rb_reg;
        q_next       = q_reg;
        off_next     = off_reg;
        claimed_next = claimed_reg;
        ever_next    = ever_reg;
        und_next     = und_reg;
        clr_next     = clr_reg;
        k_next       = k_reg;
        sil_next     = sil_reg;
        ok_next      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = store_addr(wb_reg, IW'(fidx_reg));
        ram_wdata    = smp_reg;

        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
            clr_next  = clr_reg + ADDR_W'(1);
        end

        if (cmd.latch)
        begin
            k_next   = '0;
            sil_next = '0;
        end

        if (cmd.exec_op)
        begin
            case (act_reg)
                ACT_ACQUIRE:
                begin
                    if (!claimed_reg && (q_reg < blk_eff))
                    begin
                        claimed_next = 1'b1;
                        ok_next      = 1'b1;
                    end
                end
                ACT_WRITE:
                begin
                    if (claimed_reg && (IW'(fidx_reg) < IW'(fpb_eff)))
                    begin
                        ram_we  = 1'b1;
                        ok_next = 1'b1;
                    end
                end
                ACT_COMMIT:
                begin
                    if (claimed_reg)
                    begin
                        wb_next      = next_blk(wb_reg, blk_eff);
                        q_next       = q_reg + QCNT_W'(1);
                        ever_next    = 1'b1;
                        claimed_next = 1'b0;
                        ok_next      = 1'b1;
                    end
                end
                ACT_PULL:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end

        if (cmd.exec_frame)
        begin
            ok_next  = 1'b1;
            k_next   = k_reg + CNT_W'(1);
            q_next   = q1;
            off_next = off1;
            rb_next  = rb1;
            if (fr_play)
            begin
                ram_re   = 1'b1;
                ram_addr = store_addr(rb1, IW'(off1));
                if (fr_rel)
                begin
                    off_next = '0;
                    rb_next  = next_blk(rb1, blk_eff);
                    q_next   = q1 - QCNT_W'(1);
                end
                else
                begin
                    off_next = OFF_W'(off_inc);
                end
            end
            else if (sil_reg == '0)
            begin
                sil_next = sil_start - CNT_W'(1);
                und_next = und_inc;
            end
            else
            begin
                sil_next = sil_reg - CNT_W'(1);
            end
        end

        p_valid_next = exec ? 1'b1 : (p_move ? 1'b0 : p_valid_reg);
        o_valid_next = p_move ? 1'b1 : (o_take ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpb_cfg_reg <= FPB_RESET;
            blk_cfg_reg <= BLK_RESET;
            wb_reg      <= '0;
            rb_reg      <= '0;
            q_reg       <= '0;
            off_reg     <= '0;
            claimed_reg <= 1'b0;
            ever_reg    <= 1'b0;
            und_reg     <= '0;
            clr_reg     <= '0;
            k_reg       <= '0;
            sil_reg     <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_FRAMES_PER_BLOCK))
            begin
                fpb_cfg_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_BLOCKS_IN_USE))
            begin
                blk_cfg_reg <= cfg_data[CFG_BLK_W-1:0];
            end
            wb_reg      <= wb_next;
            rb_reg      <= rb_next;
            q_reg       <= q_next;
            off_reg     <= off_next;
            claimed_reg <= claimed_next;
            ever_reg    <= ever_next;
            und_reg     <= und_next;
            clr_reg     <= clr_next;
            k_reg       <= k_next;
            sil_reg     <= sil_next;
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= action_t'(action);
            fidx_reg <= frame_index;
            smp_reg  <= {right_in, left_in};
            cnt_reg  <= (pull_count > PULL_LIMIT) ? PULL_LIMIT : pull_count;
        end
        if (exec)
        begin
            p_play_reg  <= cmd.exec_frame && fr_play;
            p_last_reg  <= cmd.exec_op || frame_last;
            p_ok_reg    <= ok_next;
            p_q_reg     <= q_next;
            p_space_reg <= q_next < blk_eff;
            p_und_reg   <= und_next;
        end
        if (p_move)
        begin
            o_left_reg  <= p_play_reg ? ram_rdata[SMP_W-1:0] : '0;
            o_right_reg <= p_play_reg ? ram_rdata[2*SMP_W-1:SMP_W] : '0;
            o_last_reg  <= p_last_reg;
            o_ok_reg    <= p_ok_reg;
            o_q_reg     <= p_q_reg;
            o_space_reg <= p_space_reg;
            o_und_reg   <= p_und_reg;
        end
    end

    assign status.clear_last = clr_reg == ADDR_W'(DEPTH - 1);
    assign status.is_pull    = act_reg == ACT_PULL;
    assign status.pull_zero  = cnt_reg == '0;
    assign status.frame_last = frame_last;
    assign status.issue_ok   = !p_valid_reg || o_take;

    assign out_valid      = o_valid_reg;
    assign left_out       = o_left_reg;
    assign right_out      = o_right_reg;
    assign last           = o_last_reg;
    assign ok             = o_ok_reg;
    assign queued_blocks  = o_q_reg;
    assign has_space      = o_space_reg;
    assign underrun_count = o_und_reg;

endmodule

/* hdl/audio_block_ring_playback.sv */
// Audio block ring playback: top level joining sequencer, datapath and sample RAM.
// Each item gives one result, and a pull of one or more frames gives one per frame,
// one frame per cycle while the consumer keeps up; a new item is taken only after
// every result of the previous one has been issued. Reset clears all ring state;
// then a clearing pass zeroes every word of the sample RAM
// (MAX_RING_BLOCKS * MAX_BLOCK_FRAMES words, 4096 by default), with in_stall high.
module audio_block_ring_playback import abrp_pkg::*; #(
    parameter int MAX_RING_BLOCKS  = 16,
    parameter int MAX_BLOCK_FRAMES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [ACT_W-1:0]        action,
    input  logic [FIDX_W-1:0]       frame_index,
    input  logic signed [SMP_W-1:0] left_in,
    input  logic signed [SMP_W-1:0] right_in,
    input  logic [CNT_W-1:0]        pull_count,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [SMP_W-1:0] left_out,
    output logic signed [SMP_W-1:0] right_out,
    output logic                    last,
    output logic                    ok,
    output logic [QCNT_W-1:0]       queued_blocks,
    output logic                    has_space,
    output logic [UND_W-1:0]        underrun_count
);

    localparam int DEPTH  = MAX_RING_BLOCKS * MAX_BLOCK_FRAMES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ctrl_cmd_t          cmd;
    dp_status_t         status;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [2*SMP_W-1:0] ram_wdata;
    logic [2*SMP_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    abrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    abrp_dpath #(
        .MAX_RING_BLOCKS  (MAX_RING_BLOCKS),
        .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .frame_index    (frame_index),
        .left_in        (left_in),
        .right_in       (right_in),
        .pull_count     (pull_count),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .left_out       (left_out),
        .right_out      (right_out),
        .last           (last),
        .ok             (ok),
        .queued_blocks  (queued_blocks),
        .has_space      (has_space),
        .underrun_count (underrun_count),
        .ram_we         (ram_we),
        .ram_re         (ram_re),
        .ram_addr       (ram_addr),
        .ram_wdata      (ram_wdata),
        .ram_rdata      (ram_rdata)
    );

    abrp_ram #(
        .WIDTH (2 * SMP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // a taken item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item taken while previous one still starting");

    // multi-result items are pulls, which always report ok
    a_multi_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> ok)
        else $error("non-final result without ok");

    // a refused request is a single silent result
    a_refused_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> last && (left_out == '0) && (right_out == '0))
        else $error("refused request carries samples or more results");

    // RAM never read and written in the same cycle
    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("sample RAM read and write collide");

endmodule
